// ===== rtl/eqsr_pkg.sv =====
// Shared constants, codes and types of the event queue subscriber router.
package eqsr_pkg;

    localparam int RING_DEPTH  = 64;
    localparam int SLOT_COUNT  = 32;
    localparam int EVENT_TYPES = 32;

    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam int FILL_W  = $clog2(RING_DEPTH + 1);
    localparam int STEP_W  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int IN_DATA_W  = 424;
    localparam int OUT_DATA_W = 496;

    typedef enum logic [1:0] {
        CMD_PUBLISH     = 2'd0,
        CMD_DISPATCH    = 2'd1,
        CMD_SUBSCRIBE   = 2'd2,
        CMD_UNSUBSCRIBE = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INVALID   = 3'd1,
        ST_DROPPED   = 3'd2,
        ST_TABLE     = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_EMPTY     = 3'd5,
        ST_DELIVERED = 3'd6,
        ST_NO_SUB    = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic        active;
        logic [7:0]  etype;
        logic [31:0] handler;
        logic [63:0] context_tag;
    } t_slot;

    typedef struct packed {
        logic [63:0] arg_four;
        logic [63:0] arg_three;
        logic [63:0] arg_two;
        logic [63:0] arg_one;
        logic [63:0] timestamp;
        logic [7:0]  etype;
    } t_event;

endpackage

// ===== rtl/eqsr_cell.sv =====
// One subscriber slot of the rotating slot chain.
module eqsr_cell
    import eqsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  t_slot i_d,
    output t_slot o_q
);

    logic        r_active;
    logic [7:0]  r_etype;
    logic [31:0] r_handler;
    logic [63:0] r_context;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (i_shift) begin
            r_active <= i_d.active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_etype   <= i_d.etype;
            r_handler <= i_d.handler;
            r_context <= i_d.context_tag;
        end
    end

    assign o_q = '{active: r_active, etype: r_etype, handler: r_handler,
                   context_tag: r_context};

endmodule

// ===== rtl/event_queue_subscriber_router_top.sv =====
// Publish and rejected commands give their transaction in the cycle after acceptance.
// Subscribe, unsubscribe and dispatch rotate the slot chain once in S_SCAN, which holds while a
// delivery waits on the receiver; S_FINISH then registers the final transaction. No command is
// taken meanwhile; other commands one per cycle while the receiver takes each transaction.
// Reset (synchronous, active low) empties the ring, clears the counter and frees all slots;
// ring and slot payload storage is not cleared and needs no clearing pass.
module event_queue_subscriber_router_top
    import eqsr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // event_type[7:0], timestamp[71:8], arg_one[135:72], arg_two[199:136],
    // arg_three[263:200], arg_four[327:264], handler_tag[359:328], context_tag[423:360]
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // cmd[1:0]
    input  logic [1:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // status[2:0], out_type[10:3], out_timestamp[74:11], out_arg_one[138:75],
    // out_arg_two[202:139], out_arg_three[266:203], out_arg_four[330:267],
    // out_handler[362:331], out_context[426:363], published_total[490:427], zeros above
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    t_state      r_state, n_state;
    t_cmd        r_cmd;
    logic [7:0]  r_req_type;
    logic [31:0] r_req_handler;
    logic [63:0] r_req_context;
    logic [STEP_W-1:0] r_step;
    logic        r_done;
    logic        r_pend_valid;
    logic [31:0] r_pend_handler;
    logic [63:0] r_pend_context;

    t_event      r_mem [RING_DEPTH];
    t_event      r_rd;
    logic [RING_AW-1:0] r_head, r_tail;
    logic [FILL_W-1:0]  r_fill;
    logic [63:0] r_count;

    logic        r_ovalid;
    t_status     r_o_status;
    t_event      r_o_evt;
    logic [31:0] r_o_handler;
    logic [63:0] r_o_context;
    logic [63:0] r_o_total;
    logic        r_o_last;

    t_slot       cell_q [SLOT_COUNT];
    t_slot       ret_slot;

    t_cmd        in_cmd;
    t_event      in_evt;
    logic [31:0] in_handler;
    logic [63:0] in_context;
    logic        s_accept, out_free, type_ok, ring_full, ring_empty;
    logic        hit, step, set_done, pend_load;
    logic        out_load, out_last, out_with_evt, cnt_inc, ring_wr, ring_rd;
    t_status     out_status;
    logic [31:0] out_handler;
    logic [63:0] out_context;

    assign in_cmd     = t_cmd'(i_s_tuser);
    assign in_evt     = '{arg_four: i_s_tdata[327:264], arg_three: i_s_tdata[263:200],
                          arg_two: i_s_tdata[199:136], arg_one: i_s_tdata[135:72],
                          timestamp: i_s_tdata[71:8], etype: i_s_tdata[7:0]};
    assign in_handler = i_s_tdata[359:328];
    assign in_context = i_s_tdata[423:360];

    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign type_ok    = {1'b0, in_evt.etype} < 9'(EVENT_TYPES);
    assign ring_full  = r_fill == FILL_W'(RING_DEPTH);
    assign ring_empty = r_fill == '0;

    // Slot chain: each cell takes its neighbour's slot; the head slot returns at the tail.
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
        localparam int NXT = (g + 1) % SLOT_COUNT;
        t_slot d;
        assign d = (g == SLOT_COUNT - 1) ? ret_slot : cell_q[NXT];
        eqsr_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (step),
            .i_d     (d),
            .o_q     (cell_q[g])
        );
    end

    assign hit = cell_q[0].active && (cell_q[0].etype == r_rd.etype);

    always_comb begin
        n_state      = r_state;
        step         = 1'b0;
        set_done     = 1'b0;
        pend_load    = 1'b0;
        ret_slot     = cell_q[0];
        out_load     = 1'b0;
        out_status   = ST_OK;
        out_handler  = '0;
        out_context  = '0;
        out_last     = 1'b1;
        out_with_evt = 1'b0;
        cnt_inc      = 1'b0;
        ring_wr      = 1'b0;
        ring_rd      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (in_cmd)
                        CMD_PUBLISH: begin
                            out_load = 1'b1;
                            if (!type_ok) begin
                                out_status = ST_INVALID;
                            end else begin
                                cnt_inc    = 1'b1;
                                ring_wr    = !ring_full;
                                out_status = ring_full ? ST_DROPPED : ST_OK;
                            end
                        end
                        CMD_DISPATCH: begin
                            if (ring_empty) begin
                                out_load   = 1'b1;
                                out_status = ST_EMPTY;
                            end else begin
                                ring_rd = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        CMD_SUBSCRIBE, CMD_UNSUBSCRIBE: begin
                            if (!type_ok || in_handler == '0) begin
                                out_load   = 1'b1;
                                out_status = ST_INVALID;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                unique case (r_cmd)
                    CMD_DISPATCH: begin
                        // Hold the chain while an earlier delivery cannot leave.
                        if (hit && r_pend_valid) begin
                            step         = out_free;
                            out_load     = out_free;
                            out_status   = ST_DELIVERED;
                            out_handler  = r_pend_handler;
                            out_context  = r_pend_context;
                            out_last     = 1'b0;
                            out_with_evt = 1'b1;
                        end else begin
                            step = 1'b1;
                        end
                        pend_load = step && hit;
                    end
                    CMD_SUBSCRIBE: begin
                        step = 1'b1;
                        if (!r_done && !cell_q[0].active) begin
                            ret_slot = '{active: 1'b1, etype: r_req_type,
                                         handler: r_req_handler,
                                         context_tag: r_req_context};
                            set_done = 1'b1;
                        end
                    end
                    CMD_UNSUBSCRIBE: begin
                        step = 1'b1;
                        if (!r_done && cell_q[0].active && cell_q[0].etype == r_req_type
                            && cell_q[0].handler == r_req_handler
                            && cell_q[0].context_tag == r_req_context) begin
                            ret_slot.active = 1'b0;
                            set_done        = 1'b1;
                        end
                    end
                    default: step = 1'b1;
                endcase
                if (step && r_step == STEP_W'(SLOT_COUNT - 1)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                    unique case (r_cmd)
                        CMD_DISPATCH: begin
                            out_with_evt = 1'b1;
                            if (r_pend_valid) begin
                                out_status  = ST_DELIVERED;
                                out_handler = r_pend_handler;
                                out_context = r_pend_context;
                            end else begin
                                out_status = ST_NO_SUB;
                            end
                        end
                        CMD_SUBSCRIBE:   out_status = r_done ? ST_OK : ST_TABLE;
                        CMD_UNSUBSCRIBE: out_status = r_done ? ST_OK : ST_NOT_FOUND;
                        default:         out_status = ST_INVALID;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_tail       <= '0;
            r_fill       <= '0;
            r_count      <= '0;
            r_ovalid     <= 1'b0;
            r_pend_valid <= 1'b0;
            r_done       <= 1'b0;
            r_step       <= '0;
        end else begin
            r_state <= n_state;
            if (ring_wr) begin
                r_tail <= (r_tail == RING_AW'(RING_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                r_fill <= r_fill + 1'b1;
            end else if (ring_rd) begin
                r_head <= (r_head == RING_AW'(RING_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_fill <= r_fill - 1'b1;
            end
            if (cnt_inc) begin
                r_count <= r_count + 64'd1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            if (s_accept) begin
                r_pend_valid <= 1'b0;
                r_done       <= 1'b0;
                r_step       <= '0;
            end else begin
                if (pend_load) begin
                    r_pend_valid <= 1'b1;
                end else if (r_state == S_FINISH && out_free) begin
                    r_pend_valid <= 1'b0;
                end
                if (set_done) begin
                    r_done <= 1'b1;
                end
                if (step) begin
                    r_step <= r_step + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ring_wr) begin
            r_mem[r_tail] <= in_evt;
        end
        if (ring_rd) begin
            r_rd <= r_mem[r_head];
        end
        if (s_accept) begin
            r_cmd         <= in_cmd;
            r_req_type    <= in_evt.etype;
            r_req_handler <= in_handler;
            r_req_context <= in_context;
        end
        if (pend_load) begin
            r_pend_handler <= cell_q[0].handler;
            r_pend_context <= cell_q[0].context_tag;
        end
        if (out_load) begin
            r_o_status  <= out_status;
            r_o_evt     <= out_with_evt ? r_rd : '0;
            r_o_handler <= out_handler;
            r_o_context <= out_context;
            r_o_total   <= cnt_inc ? r_count + 64'd1 : r_count;
            r_o_last    <= out_last;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {5'b0, r_o_total, r_o_context, r_o_handler, r_o_evt.arg_four,
                         r_o_evt.arg_three, r_o_evt.arg_two, r_o_evt.arg_one,
                         r_o_evt.timestamp, r_o_evt.etype, r_o_status};

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(RING_DEPTH))
        else $error("ring fill beyond depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill == '0 |-> r_head == r_tail)
        else $error("empty ring with unequal pointers");

    a_count_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_cmd == CMD_PUBLISH && type_ok |=> r_count == $past(r_count) + 64'd1)
        else $error("publish counter did not advance");

    a_pend_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_valid |-> (r_state == S_SCAN || r_state == S_FINISH))
        else $error("pending delivery outside a dispatch");
`endif

endmodule

// ===== dv/event_queue_subscriber_router_top_tb.sv =====
// Self-checking testbench of the event queue subscriber router top level.
module event_queue_subscriber_router_top_tb;
    import eqsr_pkg::*;

    typedef struct {
        t_cmd        cmd;
        logic [7:0]  etype;
        logic [63:0] tstamp;
        logic [63:0] a1, a2, a3, a4;
        logic [31:0] handler;
        logic [63:0] ctx;
    } t_request;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  etype;
        logic [63:0] tstamp;
        logic [63:0] a1, a2, a3, a4;
        logic [31:0] handler;
        logic [63:0] ctx;
        logic [63:0] total;
        logic        last;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // event_type, timestamp, arg_one..arg_four, handler_tag, context_tag
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    // cmd
    logic [1:0]            i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // status, out_type, out_timestamp, out_arg_one..four, out_handler,
    // out_context, published_total
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  o_m_tlast;

    event_queue_subscriber_router_top DUT (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [7:0]  q_type [RING_DEPTH];
    logic [63:0] q_time [RING_DEPTH];
    logic [63:0] q_a1 [RING_DEPTH], q_a2 [RING_DEPTH], q_a3 [RING_DEPTH], q_a4 [RING_DEPTH];
    int          q_head, q_tail, q_fill;
    logic [63:0] pub_count;
    logic        sub_on [SLOT_COUNT];
    logic [7:0]  sub_type [SLOT_COUNT];
    logic [31:0] sub_handler [SLOT_COUNT];
    logic [63:0] sub_ctx [SLOT_COUNT];

    t_request pending_requests[$];
    t_outcome expected_outcomes[$];
    int       mismatches = 0;
    bit       quiet = 1'b0;     // no idling in the last part
    bit       hold_long = 1'b0;
    int       src_gap = 0, snk_gap = 0;
    bit       stim_done = 1'b0;

    function automatic t_outcome plain_outcome(logic [2:0] st);
        t_outcome o;
        o = '{default: '0};
        o.status = st;
        o.total = pub_count;
        o.last = 1'b1;
        return o;
    endfunction

    function automatic void predict_request(t_request r);
        t_outcome o;
        bit type_ok;
        int n;
        int h;
        type_ok = r.etype < EVENT_TYPES;
        n = 0;
        case (r.cmd)
            CMD_PUBLISH: begin
                if (!type_ok) begin
                    expected_outcomes.push_back(plain_outcome(ST_INVALID));
                    return;
                end
                if (q_fill < RING_DEPTH) begin
                    q_type[q_tail] = r.etype;
                    q_time[q_tail] = r.tstamp;
                    q_a1[q_tail] = r.a1;
                    q_a2[q_tail] = r.a2;
                    q_a3[q_tail] = r.a3;
                    q_a4[q_tail] = r.a4;
                    q_tail = (q_tail + 1) % RING_DEPTH;
                    q_fill++;
                    pub_count++;
                    expected_outcomes.push_back(plain_outcome(ST_OK));
                end else begin
                    pub_count++;
                    expected_outcomes.push_back(plain_outcome(ST_DROPPED));
                end
            end
            CMD_DISPATCH: begin
                if (q_fill == 0) begin
                    expected_outcomes.push_back(plain_outcome(ST_EMPTY));
                    return;
                end
                h = q_head;
                q_head = (q_head + 1) % RING_DEPTH;
                q_fill--;
                o = plain_outcome(ST_DELIVERED);
                o.etype = q_type[h];
                o.tstamp = q_time[h];
                o.a1 = q_a1[h];
                o.a2 = q_a2[h];
                o.a3 = q_a3[h];
                o.a4 = q_a4[h];
                o.last = 1'b0;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (sub_on[i] && sub_type[i] == q_type[h]) begin
                        o.handler = sub_handler[i];
                        o.ctx = sub_ctx[i];
                        expected_outcomes.push_back(o);
                        n++;
                    end
                end
                if (n == 0) begin
                    o.status = ST_NO_SUB;
                    o.last = 1'b1;
                    expected_outcomes.push_back(o);
                end else begin
                    expected_outcomes[$].last = 1'b1;
                end
            end
            default: begin
                if (!type_ok || r.handler == 0) begin
                    expected_outcomes.push_back(plain_outcome(ST_INVALID));
                    return;
                end
                if (r.cmd == CMD_SUBSCRIBE) begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (!sub_on[i]) begin
                            sub_on[i] = 1'b1;
                            sub_type[i] = r.etype;
                            sub_handler[i] = r.handler;
                            sub_ctx[i] = r.ctx;
                            expected_outcomes.push_back(plain_outcome(ST_OK));
                            return;
                        end
                    end
                    expected_outcomes.push_back(plain_outcome(ST_TABLE));
                end else begin
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (sub_on[i] && sub_type[i] == r.etype &&
                            sub_handler[i] == r.handler && sub_ctx[i] == r.ctx) begin
                            sub_on[i] = 1'b0;
                            expected_outcomes.push_back(plain_outcome(ST_OK));
                            return;
                        end
                    end
                    expected_outcomes.push_back(plain_outcome(ST_NOT_FOUND));
                end
            end
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // pick wide values, sometimes extremes
    function automatic logic [63:0] pick64();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return rand64();
        endcase
    endfunction

    // handler and context pools keep unsubscribe hits likely
    function automatic t_request make_request(t_cmd c, logic [7:0] et);
        t_request r;
        r.cmd = c;
        r.etype = et;
        r.tstamp = pick64();
        r.a1 = pick64();
        r.a2 = pick64();
        r.a3 = pick64();
        r.a4 = pick64();
        r.handler = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 4);
        r.ctx = ($urandom_range(0, 3) == 0) ? rand64() : 64'($urandom_range(0, 3));
        return r;
    endfunction

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(EVENT_TYPES, 255));
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 3));
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                predict_request(pending_requests.pop_front());
            if (src_gap > 0 && !(i_s_tvalid && !o_s_tready)) begin
                src_gap <= src_gap - 1;
                i_s_tvalid <= 1'b0;
            end else if (!(i_s_tvalid && !o_s_tready)) begin
                if (pending_requests.size() > 0) begin
                    if (!quiet && $urandom_range(0, 9) == 0) begin
                        src_gap <= $urandom_range(1, 15);
                        i_s_tvalid <= 1'b0;
                    end else begin
                        i_s_tvalid <= 1'b1;
                        i_s_tuser <= pending_requests[0].cmd;
                        i_s_tdata <= {pending_requests[0].ctx, pending_requests[0].handler,
                                      pending_requests[0].a4, pending_requests[0].a3,
                                      pending_requests[0].a2, pending_requests[0].a1,
                                      pending_requests[0].tstamp, pending_requests[0].etype};
                    end
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.status = o_m_tdata[2:0];
                got.etype = o_m_tdata[10:3];
                got.tstamp = o_m_tdata[74:11];
                got.a1 = o_m_tdata[138:75];
                got.a2 = o_m_tdata[202:139];
                got.a3 = o_m_tdata[266:203];
                got.a4 = o_m_tdata[330:267];
                got.handler = o_m_tdata[362:331];
                got.ctx = o_m_tdata[426:363];
                got.total = o_m_tdata[490:427];
                got.last = o_m_tlast;
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected transaction: status %0d", got.status);
                end else begin
                    want = expected_outcomes.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display(
                                "mismatch: exp st%0d ty%0h ts%0h a%0h/%0h/%0h/%0h",
                                want.status, want.etype, want.tstamp, want.a1, want.a2,
                                want.a3, want.a4, " h%0h c%0h n%0h l%0b",
                                want.handler, want.ctx, want.total, want.last,
                                " got st%0d ty%0h ts%0h a%0h/%0h/%0h/%0h",
                                got.status, got.etype, got.tstamp, got.a1,
                                got.a2, got.a3, got.a4, " h%0h c%0h n%0h l%0b",
                                got.handler, got.ctx, got.total, got.last);
                    end
                end
            end
            if (hold_long)
                i_m_tready <= 1'b0;
            else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                snk_gap <= $urandom_range(1, 15);
                i_m_tready <= 1'b0;
            end else
                i_m_tready <= 1'b1;
        end
    end

    // long receiver hold-off, counted in cycles
    initial begin
        repeat (300) @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (600) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin
        #8000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        t_request r;
        // directed part
        for (int i = 0; i < 4; i++) begin
            r = make_request(CMD_SUBSCRIBE, 8'(i % 2));
            r.handler = (i == 3) ? 32'hFFFF_FFFF : 32'(i + 1);
            r.ctx = (i == 3) ? '1 : 64'(i);
            pending_requests.push_back(r);
        end
        pending_requests.push_back(make_request(CMD_DISPATCH, 8'd0));   // empty ring
        r = make_request(CMD_PUBLISH, 8'd0);
        r.tstamp = '1; r.a1 = '1; r.a2 = '0; r.a3 = '1; r.a4 = '0;
        pending_requests.push_back(r);
        r = make_request(CMD_PUBLISH, 8'(EVENT_TYPES - 1));
        r.tstamp = '0; r.a1 = '0; r.a2 = '1; r.a3 = '0; r.a4 = '1;
        pending_requests.push_back(r);
        pending_requests.push_back(make_request(CMD_PUBLISH, 8'(EVENT_TYPES)));
        pending_requests.push_back(make_request(CMD_PUBLISH, 8'hFF));
        pending_requests.push_back(make_request(CMD_DISPATCH, 8'd0));   // two matches
        pending_requests.push_back(make_request(CMD_DISPATCH, 8'd0));   // no subscriber
        r = make_request(CMD_SUBSCRIBE, 8'd2); r.handler = 0;
        pending_requests.push_back(r);
        r = make_request(CMD_UNSUBSCRIBE, 8'd1); r.handler = 32'hFFFF_FFFF; r.ctx = '1;
        pending_requests.push_back(r);
        r = make_request(CMD_UNSUBSCRIBE, 8'd1); r.handler = 32'hFFFF_FFFF; r.ctx = '1;
        pending_requests.push_back(r);                                  // not found
        r = make_request(CMD_UNSUBSCRIBE, 8'hFF);
        pending_requests.push_back(r);
        // random part: fill table and ring, drop some, mix commands, then dispatch
        for (int i = 0; i < 34; i++)
            pending_requests.push_back(make_request(CMD_SUBSCRIBE, pick_type()));
        for (int i = 0; i < 85; i++)
            pending_requests.push_back(make_request(CMD_PUBLISH,
                (i % 8 == 0) ? pick_type() : 8'($urandom_range(0, 3))));
        for (int i = 0; i < 16; i++)
            pending_requests.push_back(make_request(t_cmd'($urandom_range(0, 3)), pick_type()));
        for (int i = 0; i < 50; i++)
            pending_requests.push_back(make_request(CMD_DISPATCH, 8'd0));

        for (int i = 0; i < RING_DEPTH; i++) begin
            q_type[i] = '0; q_time[i] = '0;
            q_a1[i] = '0; q_a2[i] = '0; q_a3[i] = '0; q_a4[i] = '0;
        end
        q_head = 0; q_tail = 0; q_fill = 0; pub_count = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            sub_on[i] = 1'b0; sub_type[i] = '0; sub_handler[i] = '0; sub_ctx[i] = '0;
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_requests.size() > 40) @(posedge i_clk);
        quiet <= 1'b1;
        while (pending_requests.size() > 0 || expected_outcomes.size() > 0)
            @(posedge i_clk);
        repeat (4 * SLOT_COUNT) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
